@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the encoder angle tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ sv/eat_pkg.sv @@
// Package: constants, control word types and microcode ROM of the encoder angle tracker.
`default_nettype none

package eat_pkg;

    localparam int ANGLE_BITS      = 12;
    localparam int COUNTS_PER_TURN = 1 << ANGLE_BITS;
    localparam int REV_BITS        = ANGLE_BITS + 1;
    localparam int WRAP_LIMIT      = (4 * COUNTS_PER_TURN) / 5;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
    localparam int TURN_BITS_DEF   = 20;
    localparam int TICK_BITS       = 32;
    localparam int POLE_BITS       = 7;
    localparam int TPS_BITS        = 20;
    localparam int DIV_STEPS       = 32;
    localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);

    localparam logic [POLE_BITS-1:0] POLE_PAIRS_RST = POLE_BITS'(7);
    localparam logic [TPS_BITS-1:0]  TPS_RST        = TPS_BITS'(1000000);

    typedef enum logic [1:0] {
        REG_ZERO_OFFSET = 2'd0,
        REG_POLE_PAIRS  = 2'd1,
        REG_TICKS_PER_S = 2'd2
    } t_reg_idx;

    typedef logic [2:0] t_pc;

    localparam t_pc PC_LOAD = 3'd0;
    localparam t_pc PC_DIFF = 3'd1;
    localparam t_pc PC_MUL  = 3'd2;
    localparam t_pc PC_DIV  = 3'd3;
    localparam t_pc PC_OUT  = 3'd4;

    typedef enum logic [1:0] {
        WAIT_NONE  = 2'd0,
        WAIT_INPUT = 2'd1,
        WAIT_DIV   = 2'd2,
        WAIT_OUT   = 2'd3
    } t_wait;

    typedef enum logic [1:0] {
        JMP_NEVER      = 2'd0,
        JMP_ALWAYS     = 2'd1,
        JMP_TICKS_ZERO = 2'd2
    } t_jump;

    typedef struct packed {
        logic  in_ready;
        logic  ld_diff;
        logic  ld_mul;
        logic  div_step;
        logic  ld_out;
        t_wait wait_sel;
        t_jump jump_sel;
        t_pc   target;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic ticks_zero;
        logic div_busy;
        logic out_busy;
    } t_status;

    function automatic t_ctl ucode(input t_pc pc);
        t_ctl w;
        w.in_ready = 1'b0;
        w.ld_diff  = 1'b0;
        w.ld_mul   = 1'b0;
        w.div_step = 1'b0;
        w.ld_out   = 1'b0;
        w.wait_sel = WAIT_NONE;
        w.jump_sel = JMP_NEVER;
        w.target   = PC_LOAD;
        case (pc)
            PC_LOAD: begin
                w.in_ready = 1'b1;
                w.wait_sel = WAIT_INPUT;
            end
            PC_DIFF: begin
                w.ld_diff = 1'b1;
            end
            PC_MUL: begin
                w.ld_mul   = 1'b1;
                w.jump_sel = JMP_TICKS_ZERO;
                w.target   = PC_OUT;
            end
            PC_DIV: begin
                w.div_step = 1'b1;
                w.wait_sel = WAIT_DIV;
            end
            PC_OUT: begin
                w.ld_out   = 1'b1;
                w.wait_sel = WAIT_OUT;
                w.jump_sel = JMP_ALWAYS;
                w.target   = PC_LOAD;
            end
            default: begin
                w.jump_sel = JMP_ALWAYS;
                w.target   = PC_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ sv/encoder_angle_tracker_unit.sv @@
// Top level of the encoder angle tracker: ports, configuration registers and assertions.
`default_nettype none

// Takes one sensor sample (raw angle, elapsed timer ticks) per input transaction and returns
// one result: multi-turn position, electrical angle and signed speed in counts per second.
// A sample with nonzero elapsed ticks passes one accept step, two compute steps, 32 steps
// of the one-bit-per-cycle restoring divider and one output step, which loads the result
// register. With zero elapsed ticks the divider steps are skipped.
// The output step stalls while the previous result still waits in the output register.
// The next sample is taken while the previous result still waits in the output register.
// The turn count wraps within TURN_BITS bits; position wraps modulo 2^32.
// Configuration is written through the cfg channel, index 0 zero offset, 1 pole pairs,
// 2 ticks per second; index 3 is ignored. Write it only while the block is idle.
module encoder_angle_tracker_unit #(
    parameter int TURN_BITS = eat_pkg::TURN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // raw_angle[11:0], elapsed_ticks[43:12], zero pad
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [79:0]      o_m_tdata,   // position[31:0], electrical_angle[43:32],
                                          // speed[75:44], zero pad
    output logic [0:0]       o_m_tuser,   // speed_valid[0]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);

    `include "assert_macros.svh"

    logic [eat_pkg::ANGLE_BITS-1:0] r_zero_offset;
    logic [eat_pkg::POLE_BITS-1:0]  r_pole_pairs;
    logic [eat_pkg::TPS_BITS-1:0]   r_tps;

    eat_pkg::t_ctl    w_ctl;
    eat_pkg::t_pc     w_pc;
    eat_pkg::t_status w_dp_status;
    eat_pkg::t_status w_status;
    logic             w_accept;
    logic [31:0]      w_position;
    logic [eat_pkg::ANGLE_BITS-1:0] w_elec;
    logic [31:0]      w_speed;
    logic             w_speed_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
            r_pole_pairs  <= eat_pkg::POLE_PAIRS_RST;
            r_tps         <= eat_pkg::TPS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                eat_pkg::REG_ZERO_OFFSET: r_zero_offset <= i_cfg_data[eat_pkg::ANGLE_BITS-1:0];
                eat_pkg::REG_POLE_PAIRS:  r_pole_pairs  <= i_cfg_data[eat_pkg::POLE_BITS-1:0];
                eat_pkg::REG_TICKS_PER_S: r_tps         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_tready = w_ctl.in_ready;
    assign w_accept   = i_s_tvalid && w_ctl.in_ready;

    assign w_status.in_valid   = i_s_tvalid;
    assign w_status.ticks_zero = w_dp_status.ticks_zero;
    assign w_status.div_busy   = w_dp_status.div_busy;
    assign w_status.out_busy   = w_dp_status.out_busy;

    eat_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctl    (w_ctl),
        .o_pc     (w_pc)
    );

    eat_datapath #(
        .TURN_BITS (TURN_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_ctl),
        .i_accept           (w_accept),
        .i_raw_angle        (i_s_tdata[11:0]),
        .i_elapsed_ticks    (i_s_tdata[43:12]),
        .i_zero_offset      (r_zero_offset),
        .i_pole_pairs       (r_pole_pairs),
        .i_ticks_per_second (r_tps),
        .i_out_ready        (i_m_tready),
        .o_status           (w_dp_status),
        .o_out_valid        (o_m_tvalid),
        .o_position         (w_position),
        .o_electrical_angle (w_elec),
        .o_speed            (w_speed),
        .o_speed_valid      (w_speed_valid)
    );

    assign o_m_tdata = {4'd0, w_speed, w_elec, w_position};
    assign o_m_tuser = w_speed_valid;

    `ASSERT_CLK(a_ready_at_load, i_clk, i_rst_n, o_s_tready |-> (w_pc == eat_pkg::PC_LOAD), "input ready outside load step")
    `ASSERT_CLK(a_accept_to_diff, i_clk, i_rst_n, w_accept |=> (w_pc == eat_pkg::PC_DIFF), "accepted sample not followed by compute step")
    `ASSERT_CLK(a_result_from_out, i_clk, i_rst_n, $rose(o_m_tvalid) |-> ($past(w_pc) == eat_pkg::PC_OUT), "result valid raised outside output step")

endmodule

`default_nettype wire

@@ sv/eat_sequencer.sv @@
// Microcode sequencer: step counter, control ROM lookup, wait and jump logic.
`default_nettype none

module eat_sequencer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire eat_pkg::t_status i_status,
    output eat_pkg::t_ctl         o_ctl,
    output eat_pkg::t_pc          o_pc
);

    eat_pkg::t_pc  r_pc;
    eat_pkg::t_pc  n_pc;
    eat_pkg::t_ctl w_ctl;
    logic          w_wait;
    logic          w_jump;

    assign w_ctl = eat_pkg::ucode(r_pc);

    always_comb begin
        unique case (w_ctl.wait_sel)
            eat_pkg::WAIT_NONE:  w_wait = 1'b0;
            eat_pkg::WAIT_INPUT: w_wait = !i_status.in_valid;
            eat_pkg::WAIT_DIV:   w_wait = i_status.div_busy;
            eat_pkg::WAIT_OUT:   w_wait = i_status.out_busy;
            default:             w_wait = 1'b0;
        endcase
    end

    always_comb begin
        unique case (w_ctl.jump_sel)
            eat_pkg::JMP_NEVER:      w_jump = 1'b0;
            eat_pkg::JMP_ALWAYS:     w_jump = 1'b1;
            eat_pkg::JMP_TICKS_ZERO: w_jump = i_status.ticks_zero;
            default:                 w_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (w_wait) begin
            n_pc = r_pc;
        end else if (w_jump) begin
            n_pc = w_ctl.target;
        end else begin
            n_pc = r_pc + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= eat_pkg::PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = w_ctl;
    assign o_pc  = r_pc;

endmodule

`default_nettype wire

@@ sv/eat_datapath.sv @@
// Datapath: turn tracking, position, electrical angle, speed multiply and restoring divider.
`default_nettype none

module eat_datapath #(
    parameter int TURN_BITS = eat_pkg::TURN_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire eat_pkg::t_ctl                     i_ctl,
    input  wire logic                              i_accept,
    input  wire logic [eat_pkg::ANGLE_BITS-1:0]    i_raw_angle,
    input  wire logic [eat_pkg::TICK_BITS-1:0]     i_elapsed_ticks,
    input  wire logic [eat_pkg::ANGLE_BITS-1:0]    i_zero_offset,
    input  wire logic [eat_pkg::POLE_BITS-1:0]     i_pole_pairs,
    input  wire logic [eat_pkg::TPS_BITS-1:0]      i_ticks_per_second,
    input  wire logic                              i_out_ready,
    output eat_pkg::t_status                       o_status,
    output logic                                   o_out_valid,
    output logic [31:0]                            o_position,
    output logic [eat_pkg::ANGLE_BITS-1:0]         o_electrical_angle,
    output logic [31:0]                            o_speed,
    output logic                                   o_speed_valid
);

    localparam int AB = eat_pkg::ANGLE_BITS;
    localparam int RB = eat_pkg::REV_BITS;
    localparam int DB = RB + 1;

    logic [AB-1:0]                    r_raw;
    logic [eat_pkg::TICK_BITS-1:0]    r_ticks;
    logic [RB-1:0]                    r_last;
    logic [RB-1:0]                    r_rev;
    logic [TURN_BITS-1:0]             r_turn;
    logic [AB-1:0]                    r_wd_mag;
    logic                             r_wd_neg;
    logic [AB-1:0]                    r_m;
    logic [31:0]                      r_pos;
    logic [AB-1:0]                    r_elec;
    logic [31:0]                      r_q;
    logic [31:0]                      r_rem;
    logic [eat_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic                             r_o_valid;
    logic [31:0]                      r_o_pos;
    logic [AB-1:0]                    r_o_elec;
    logic [31:0]                      r_o_speed;
    logic                             r_o_speed_valid;

    logic [RB-1:0]                    w_rev;
    logic signed [DB-1:0]             w_d;
    logic [RB-1:0]                    w_ad;
    logic signed [DB-1:0]             w_wd;
    logic [RB-1:0]                    w_wd_abs;
    logic [31:0]                      w_prod;
    logic [AB+eat_pkg::POLE_BITS-1:0] w_eprod;
    logic [31:0]                      w_turn_ext;
    logic [31:0]                      w_sum;
    logic [32:0]                      w_rem_sh;
    logic [32:0]                      w_rem_sub;
    logic                             w_ticks_zero;
    logic                             w_out_busy;
    logic                             w_load_out;

    assign w_rev = RB'(eat_pkg::COUNTS_PER_TURN) - {1'b0, r_raw};
    assign w_d   = $signed({1'b0, w_rev}) - $signed({1'b0, r_last});
    assign w_ad  = w_d[DB-1] ? RB'(-w_d) : RB'(w_d);

    always_comb begin
        if (w_d > DB'(eat_pkg::HALF_TURN)) begin
            w_wd = w_d - DB'(eat_pkg::COUNTS_PER_TURN);
        end else if (w_d < -DB'(eat_pkg::HALF_TURN)) begin
            w_wd = w_d + DB'(eat_pkg::COUNTS_PER_TURN);
        end else begin
            w_wd = w_d;
        end
    end
    assign w_wd_abs = w_wd[DB-1] ? RB'(-w_wd) : RB'(w_wd);

    assign w_prod     = 32'(r_wd_mag) * 32'(i_ticks_per_second);
    assign w_eprod    = r_m * i_pole_pairs;
    assign w_turn_ext = 32'(signed'(r_turn));
    assign w_sum      = (w_turn_ext << AB) + 32'(r_rev);

    assign w_rem_sh  = {r_rem, r_q[31]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_ticks};

    assign w_ticks_zero = (r_ticks == '0);
    assign w_out_busy   = r_o_valid && !i_out_ready;
    assign w_load_out   = i_ctl.ld_out && !w_out_busy;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_raw   <= i_raw_angle;
            r_ticks <= i_elapsed_ticks;
        end
        if (i_ctl.ld_diff) begin
            r_rev    <= w_rev;
            r_wd_mag <= AB'(w_wd_abs);
            r_wd_neg <= w_wd[DB-1];
            r_m      <= AB'(w_rev - {1'b0, i_zero_offset});
        end
        if (i_ctl.ld_mul) begin
            r_q    <= w_prod;
            r_rem  <= '0;
            r_elec <= w_eprod[AB-1:0];
            r_pos  <= 32'd0 - w_sum;
        end
        if (i_ctl.div_step) begin
            if (!w_rem_sub[32]) begin
                r_rem <= w_rem_sub[31:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[31:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
        if (w_load_out) begin
            r_o_pos         <= r_pos;
            r_o_elec        <= r_elec;
            r_o_speed_valid <= !w_ticks_zero;
            if (w_ticks_zero) begin
                r_o_speed <= '0;
            end else if (r_wd_neg) begin
                r_o_speed <= 32'd0 - r_q;
            end else begin
                r_o_speed <= r_q;
            end
        end
    end

    // turn state, divider count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_turn    <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_ctl.ld_diff) begin
                r_last <= w_rev;
                if (w_ad > RB'(eat_pkg::WRAP_LIMIT)) begin
                    if (w_d > 0) begin
                        r_turn <= r_turn - 1'b1;
                    end else begin
                        r_turn <= r_turn + 1'b1;
                    end
                end
            end
            if (i_ctl.ld_mul) begin
                r_cnt <= '0;
            end else if (i_ctl.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_status.in_valid   = 1'b0;
    assign o_status.ticks_zero = w_ticks_zero;
    assign o_status.div_busy   = (r_cnt != eat_pkg::DIV_CNT_BITS'(eat_pkg::DIV_STEPS - 1));
    assign o_status.out_busy   = w_out_busy;

    assign o_out_valid        = r_o_valid;
    assign o_position         = r_o_pos;
    assign o_electrical_angle = r_o_elec;
    assign o_speed            = r_o_speed;
    assign o_speed_valid      = r_o_speed_valid;

endmodule

`default_nettype wire

@@ tb/sv/tb_encoder_angle_tracker_unit.sv @@
// Testbench for encoder_angle_tracker_unit: directed and random samples against a predictor.
`timescale 1ns / 1ps

module tb_encoder_angle_tracker_unit;

    localparam logic [1:0] CFG_IDX_SPARE = 2'd3;
    localparam int TURN_W = eat_pkg::TURN_BITS_DEF;

    typedef struct packed {
        logic [31:0] position;
        logic [11:0] elec_angle;
        logic [31:0] speed;
        logic        speed_valid;
    } t_sample_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [47:0] s_tdata     = '0;
    logic        m_tready    = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [1:0]  cfg_index   = '0;
    logic [19:0] cfg_data    = '0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire  [79:0] o_m_tdata;
    wire  [0:0]  o_m_tuser;
    wire         o_cfg_ready;

    // predictor copy of registers and tracking state
    logic [11:0]       zero_offset_q = '0;
    logic [6:0]        pole_pairs_q  = 7'd7;
    logic [19:0]       tps_q         = 20'd1000000;
    logic [12:0]       last_rev_q    = '0;
    logic [TURN_W-1:0] turns_q       = '0;

    t_sample_result pending_results[$];
    int             mismatch_count = 0;
    bit             src_idle_en    = 1'b0;
    bit             sink_stall_en  = 1'b0;
    logic [11:0]    raw_walk       = '0;

    encoder_angle_tracker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("encoder_angle_tracker_unit regression: fail");
        $finish;
    end

    function automatic t_sample_result predict_tracker(input logic [11:0] raw,
                                                       input logic [31:0] ticks);
        t_sample_result r;
        longint rev, d, ad, wd, num, q, m, spd, sum;
        rev = longint'(eat_pkg::COUNTS_PER_TURN) - longint'(raw);
        d   = rev - longint'(last_rev_q);
        ad  = (d < 0) ? -d : d;
        if (ad * 5 > longint'(eat_pkg::COUNTS_PER_TURN) * 4) begin
            if (d > 0)
                turns_q = turns_q - 1'b1;
            else
                turns_q = turns_q + 1'b1;
        end
        wd = d;
        if (wd > eat_pkg::HALF_TURN)
            wd = wd - eat_pkg::COUNTS_PER_TURN;
        else if (wd < -eat_pkg::HALF_TURN)
            wd = wd + eat_pkg::COUNTS_PER_TURN;
        spd = 0;
        if (ticks != 0) begin
            num = wd * longint'(tps_q);
            q   = ((num < 0) ? -num : num) / longint'(ticks);
            spd = (num < 0) ? -q : q;
        end
        last_rev_q = rev[12:0];
        sum = longint'($signed(turns_q)) * eat_pkg::COUNTS_PER_TURN + rev;
        r.position = 32'(-sum);
        m = (rev - longint'(zero_offset_q)) % eat_pkg::COUNTS_PER_TURN;
        if (m < 0)
            m = m + eat_pkg::COUNTS_PER_TURN;
        r.elec_angle  = 12'((m * longint'(pole_pairs_q)) % eat_pkg::COUNTS_PER_TURN);
        r.speed       = 32'(spd);
        r.speed_valid = (ticks != 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_sample_result want;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, o_m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[31:0] !== want.position)
                    report_mismatch("position", $signed(want.position),
                                    $signed(o_m_tdata[31:0]));
                if (o_m_tdata[43:32] !== want.elec_angle)
                    report_mismatch("electrical_angle", want.elec_angle, o_m_tdata[43:32]);
                if (o_m_tdata[75:44] !== want.speed)
                    report_mismatch("speed", $signed(want.speed), $signed(o_m_tdata[75:44]));
                if (o_m_tuser[0] !== want.speed_valid)
                    report_mismatch("speed_valid", want.speed_valid, o_m_tuser[0]);
            end
        end
    end

    // result-side backpressure
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (sink_stall_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [11:0] raw, input logic [31:0] ticks);
        cfg_valid <= 1'b0;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, ticks, raw};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(predict_tracker(raw, ticks));
    endtask

    task automatic wait_for_results();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            eat_pkg::REG_ZERO_OFFSET: zero_offset_q = val[11:0];
            eat_pkg::REG_POLE_PAIRS:  pole_pairs_q  = val[6:0];
            eat_pkg::REG_TICKS_PER_S: tps_q         = val;
            default: ;
        endcase
    endtask

    // first sample compares against a zero previous angle
    task automatic test_first_sample();
        send_sample(12'd0, 32'd1000);
        send_sample(12'd4095, 32'd1);
        send_sample(12'd2048, 32'd250);
    endtask

    // wrap detection right at and past the 80% threshold, both directions
    task automatic test_turn_tracking();
        send_sample(12'd3996, 32'd1000);
        send_sample(12'd720, 32'd1000);
        send_sample(12'd3996, 32'd1000);
        send_sample(12'd719, 32'd1000);
        send_sample(12'd3996, 32'd1000);
        send_sample(12'd4000, 32'd500);
        send_sample(12'd100, 32'd500);
        send_sample(12'd4050, 32'd500);
    endtask

    task automatic test_zero_ticks();
        send_sample(12'd1234, 32'd0);
        send_sample(12'd1300, 32'd0);
        send_sample(12'd1400, 32'hFFFF_FFFF);
    endtask

    task automatic test_spare_index();
        wait_for_results();
        write_reg(CFG_IDX_SPARE, 20'hFFFFF);
        send_sample(12'd2222, 32'd77);
    endtask

    task automatic test_register_extremes();
        wait_for_results();
        write_reg(eat_pkg::REG_ZERO_OFFSET, 20'd4095);
        write_reg(eat_pkg::REG_POLE_PAIRS, 20'd64);
        write_reg(eat_pkg::REG_TICKS_PER_S, 20'd1);
        send_sample(12'd0, 32'd3);
        send_sample(12'd1, 32'd1);
        wait_for_results();
        write_reg(eat_pkg::REG_POLE_PAIRS, 20'd0);
        write_reg(eat_pkg::REG_TICKS_PER_S, 20'd0);
        send_sample(12'd500, 32'd9);
        wait_for_results();
        write_reg(eat_pkg::REG_ZERO_OFFSET, 20'd0);
        write_reg(eat_pkg::REG_POLE_PAIRS, 20'd127);
        write_reg(eat_pkg::REG_TICKS_PER_S, 20'hFFFFF);
        // half-turn steps give the largest speeds
        send_sample(12'd3000, 32'd1);
        send_sample(12'd952, 32'd1);
        send_sample(12'd3000, 32'd1);
        send_sample(12'd951, 32'd1);
        send_sample(12'd3000, 32'd7);
    endtask

    task automatic test_random_phases();
        int p, k;
        logic [11:0] raw;
        logic [31:0] ticks;
        logic [19:0] zo, pp, tps;
        for (p = 0; p < 5; p++) begin
            wait_for_results();
            case (p)
                0: begin zo = 20'd4095; pp = 20'd127; tps = 20'hFFFFF; end
                1: begin zo = 20'd0; pp = 20'd1; tps = 20'd1; end
                default: begin
                    zo  = 20'($urandom_range(0, 4095));
                    pp  = ($urandom_range(0, 7) == 0) ? 20'd0 : 20'($urandom_range(1, 64));
                    tps = ($urandom_range(0, 7) == 0) ? 20'd0
                                                      : 20'($urandom_range(1, 1000000));
                end
            endcase
            write_reg(eat_pkg::REG_ZERO_OFFSET, zo);
            write_reg(eat_pkg::REG_POLE_PAIRS, pp);
            write_reg(eat_pkg::REG_TICKS_PER_S, tps);
            src_idle_en   = (p != 4);
            sink_stall_en = (p != 4) && (p != 1);
            for (k = 0; k < 350; k++) begin
                if (p == 2 && k == 175)
                    wait_for_results();
                case ($urandom_range(0, 9))
                    0, 1: raw_walk = raw_walk + 12'(int'($urandom_range(3200, 3700)));
                    2:    raw_walk = 12'($urandom);
                    default: raw_walk = raw_walk + 12'(int'($urandom_range(0, 800)) - 400);
                endcase
                raw = raw_walk;
                case ($urandom_range(0, 19))
                    0:       ticks = '0;
                    1:       ticks = 32'hFFFF_FFFF;
                    2, 3:    ticks = $urandom;
                    4, 5, 6: ticks = $urandom_range(1, 1000);
                    default: ticks = $urandom_range(1, 2_000_000);
                endcase
                send_sample(raw, ticks);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idle_en   = 1'b1;
        sink_stall_en = 1'b1;
        test_first_sample();
        test_turn_tracking();
        test_zero_ticks();
        test_spare_index();
        test_register_extremes();
        test_random_phases();
        wait_for_results();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("encoder_angle_tracker_unit regression: pass");
        else
            $display("encoder_angle_tracker_unit regression: fail");
        $finish;
    end

endmodule
